// File: src/saa_pkg.sv
// Shared constants for the shelf atlas allocator: field widths, opcodes,
// configuration register indexes and reset values.
// No dependencies.
package saa_pkg;

  localparam int RECT_W   = 14;
  localparam int CORNER_W = 15;
  localparam int PAD_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int MAX_DIM_DEFAULT = 8192;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y = 2'd1;

  localparam logic [PAD_W-1:0]  PAD_X_RST       = 8'd1;
  localparam logic [PAD_W-1:0]  PAD_Y_RST       = 8'd1;
  localparam logic [RECT_W-1:0] INIT_WIDTH_RST  = 14'd256;
  localparam logic [RECT_W-1:0] INIT_HEIGHT_RST = 14'd256;

endpackage

// File: src/shelf_atlas_allocator_unit.sv
// Top level of the shelf atlas allocator: input register, placement logic,
// result register and configuration registers.
// Depends on saa_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: opcode add
//   with rect_width and rect_height, or opcode clear. Output channel
//   (out_valid / out_stall) returns exactly one result item per request:
//   placement corners, growth flag and the atlas size after the request.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   pad_x (index 0) and pad_y (index 1); cfg_ready is always high. Writes to
//   indexes 2 and 3 are accepted and have no effect; the initial atlas size
//   only applies at reset. Write only while the block is idle.
// Timing:
//   out_valid rises after an accepted item has gone through one input register,
//   then the placement logic feeding the result register. One item per cycle is
//   sustained while out_stall is low; the placement state updates in the same
//   edge that loads the result register, so the next item sees it immediately.
// Reset and stall:
//   rst (synchronous) empties both registers and loads head = (1, 1), shelf
//   height 0 and a 256 x 256 atlas. While out_stall is high the result holds,
//   the input register fills and in_stall rises once both are occupied.
module shelf_atlas_allocator_unit #(
  parameter int MAX_DIM = saa_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [saa_pkg::RECT_W-1:0]        rect_width,
  input  logic [saa_pkg::RECT_W-1:0]        rect_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              placed_ok,
  output logic [saa_pkg::RECT_W-1:0]        corner_x0,
  output logic [saa_pkg::RECT_W-1:0]        corner_y0,
  output logic [saa_pkg::CORNER_W-1:0]      corner_x1,
  output logic [saa_pkg::CORNER_W-1:0]      corner_y1,
  output logic                              atlas_grew,
  output logic [saa_pkg::RECT_W-1:0]        current_width,
  output logic [saa_pkg::RECT_W-1:0]        current_height,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [saa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [saa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW = $clog2(MAX_DIM + 1);
  localparam int DW = (PW > saa_pkg::RECT_W) ? PW : saa_pkg::RECT_W;
  localparam int EW = DW + 2;
  localparam logic [EW-1:0] PMAX = EW'(1) << (PW - 1);

  function automatic logic [DW-1:0] ceil_pow2(input logic [DW-1:0] v);
    logic [DW-1:0] m;
    logic          acc;
    m   = v - DW'(1);
    acc = 1'b0;
    for (int i = DW - 1; i >= 0; i--) begin
      acc  = acc | m[i];
      m[i] = acc;
    end
    return m + DW'(1);
  endfunction

  logic                        s1_valid;
  logic                        s1_opcode;
  logic [saa_pkg::RECT_W-1:0]  s1_w;
  logic [saa_pkg::RECT_W-1:0]  s1_h;
  logic                        s1_ready;
  logic                        s2_ready;
  logic                        s1_fire;

  logic [saa_pkg::PAD_W-1:0]   pad_x;
  logic [saa_pkg::PAD_W-1:0]   pad_y;
  logic [DW-1:0]               head_x;
  logic [DW-1:0]               head_y;
  logic [DW-1:0]               shelf_height;
  logic [DW-1:0]               atlas_width;
  logic [DW-1:0]               atlas_height;

  logic [DW-1:0]               head_x_next;
  logic [DW-1:0]               head_y_next;
  logic [DW-1:0]               shelf_height_next;
  logic [DW-1:0]               atlas_width_next;
  logic [DW-1:0]               atlas_height_next;
  logic                        placed_ok_next;
  logic [DW-1:0]               x0_next;
  logic [DW-1:0]               y0_next;
  logic [DW:0]                 x1_next;
  logic [DW:0]                 y1_next;
  logic                        grew_next;

  assign s2_ready  = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s1_fire   = s1_valid && s2_ready;
  assign in_stall  = !s1_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [EW-1:0] w_e;
    logic [EW-1:0] h_e;
    logic [EW-1:0] px_e;
    logic [EW-1:0] py_e;
    logic [EW-1:0] aw_e;
    logic [EW-1:0] ah_e;
    logic [EW-1:0] ex1;
    logic [EW-1:0] ey1;
    logic [EW-1:0] hy2;
    logic [EW-1:0] ex2;
    logic [EW-1:0] ey2;
    logic [EW-1:0] tx;
    logic [EW-1:0] ty;
    logic [EW-1:0] hpy;
    logic [DW-1:0] nw;
    logic [DW-1:0] nh;
    logic [DW-1:0] sh_base;
    logic          fit1;
    logic          fit2;
    logic          capped;

    w_e  = EW'(s1_w);
    h_e  = EW'(s1_h);
    px_e = EW'(pad_x);
    py_e = EW'(pad_y);
    aw_e = EW'(atlas_width);
    ah_e = EW'(atlas_height);
    ex1  = EW'(head_x) + w_e + px_e;
    ey1  = EW'(head_y) + h_e + py_e;
    hy2  = EW'(head_y) + EW'(shelf_height);
    ex2  = px_e + w_e + px_e;
    ey2  = hy2 + h_e + py_e;
    fit1 = (ex1 < aw_e) && (ey1 < ah_e);
    fit2 = (ex2 < aw_e) && (ey2 < ah_e);
    tx   = (ex2 > aw_e) ? ex2 : aw_e;
    ty   = (ey2 > ah_e) ? ey2 : ah_e;
    capped = (tx > PMAX) || (ty > PMAX);
    nw   = ceil_pow2(tx[DW-1:0]);
    nh   = ceil_pow2(ty[DW-1:0]);
    hpy  = h_e + py_e;

    head_x_next       = head_x;
    head_y_next       = head_y;
    shelf_height_next = shelf_height;
    atlas_width_next  = atlas_width;
    atlas_height_next = atlas_height;
    placed_ok_next    = 1'b0;
    x0_next           = '0;
    y0_next           = '0;
    x1_next           = '0;
    y1_next           = '0;
    grew_next         = 1'b0;
    sh_base           = shelf_height;

    case (s1_opcode)
      saa_pkg::OP_CLEAR: begin
        head_x_next       = DW'(pad_x);
        head_y_next       = DW'(pad_y);
        shelf_height_next = '0;
      end
      default: begin
        if (s1_w != '0 && s1_h != '0) begin
          if (fit1) begin
            x0_next = head_x;
            y0_next = head_y;
          end else begin
            x0_next           = DW'(pad_x);
            y0_next           = hy2[DW-1:0];
            sh_base           = '0;
            head_x_next       = DW'(pad_x);
            head_y_next       = hy2[DW-1:0];
            shelf_height_next = '0;
          end
          if (fit1 || fit2 || !capped) begin
            if (!fit1 && !fit2) begin
              atlas_width_next  = nw;
              atlas_height_next = nh;
              grew_next         = (nw != atlas_width) || (nh != atlas_height);
            end
            placed_ok_next    = 1'b1;
            x1_next           = (DW + 1)'(x0_next) + (DW + 1)'(s1_w);
            y1_next           = (DW + 1)'(y0_next) + (DW + 1)'(s1_h);
            head_x_next       = fit1 ? ex1[DW-1:0] : ex2[DW-1:0];
            shelf_height_next = (hpy > EW'(sh_base)) ? hpy[DW-1:0] : sh_base;
          end else begin
            x0_next = '0;
            y0_next = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      pad_x        <= saa_pkg::PAD_X_RST;
      pad_y        <= saa_pkg::PAD_Y_RST;
      head_x       <= DW'(saa_pkg::PAD_X_RST);
      head_y       <= DW'(saa_pkg::PAD_Y_RST);
      shelf_height <= '0;
      atlas_width  <= DW'(saa_pkg::INIT_WIDTH_RST);
      atlas_height <= DW'(saa_pkg::INIT_HEIGHT_RST);
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        head_x       <= head_x_next;
        head_y       <= head_y_next;
        shelf_height <= shelf_height_next;
        atlas_width  <= atlas_width_next;
        atlas_height <= atlas_height_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          saa_pkg::CFG_PAD_X: pad_x <= cfg_data[saa_pkg::PAD_W-1:0];
          saa_pkg::CFG_PAD_Y: pad_y <= cfg_data[saa_pkg::PAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_opcode <= opcode;
      s1_w      <= rect_width;
      s1_h      <= rect_height;
    end
    if (s1_fire) begin
      placed_ok      <= placed_ok_next;
      corner_x0      <= x0_next[saa_pkg::RECT_W-1:0];
      corner_y0      <= y0_next[saa_pkg::RECT_W-1:0];
      corner_x1      <= x1_next[saa_pkg::CORNER_W-1:0];
      corner_y1      <= y1_next[saa_pkg::CORNER_W-1:0];
      atlas_grew     <= grew_next;
      current_width  <= atlas_width_next[saa_pkg::RECT_W-1:0];
      current_height <= atlas_height_next[saa_pkg::RECT_W-1:0];
    end
  end

endmodule

// File: src/saa_checker.sv
// Port-level checker for the shelf atlas allocator, bound to the top level.
// Depends on saa_pkg and shelf_atlas_allocator_unit.
module saa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            placed_ok,
  input logic [saa_pkg::RECT_W-1:0]      corner_x0,
  input logic [saa_pkg::RECT_W-1:0]      corner_y0,
  input logic [saa_pkg::CORNER_W-1:0]    corner_x1,
  input logic [saa_pkg::CORNER_W-1:0]    corner_y1,
  input logic                            atlas_grew
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(corner_x0) && $stable(corner_x1)
      && $stable(placed_ok))
    else $error("result changed under stall");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed_ok |-> corner_x0 == '0 && corner_y0 == '0
      && corner_x1 == '0 && corner_y1 == '0 && !atlas_grew)
    else $error("failed item carries nonzero corners");

  a_grow_placed: assert property (@(posedge clk) disable iff (rst)
    out_valid && atlas_grew |-> placed_ok)
    else $error("growth reported without placement");

  a_extent: assert property (@(posedge clk) disable iff (rst)
    out_valid && placed_ok |-> corner_x1 > {1'b0, corner_x0} && corner_y1 > {1'b0, corner_y0})
    else $error("placed item has empty extent");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind shelf_atlas_allocator_unit saa_checker u_saa_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .placed_ok  (placed_ok),
  .corner_x0  (corner_x0),
  .corner_y0  (corner_y0),
  .corner_x1  (corner_x1),
  .corner_y1  (corner_y1),
  .atlas_grew (atlas_grew)
);
